// File: src/lc_trie_longest_prefix_lookup_assert.svh
// Assertion macros for the trie lookup block.
// Depends on nothing; included by the modules that carry assertions.
`ifndef LC_TRIE_LONGEST_PREFIX_LOOKUP_ASSERT_SVH
`define LC_TRIE_LONGEST_PREFIX_LOOKUP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LCT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LCT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/lct_pkg.sv
// Shared types and constants for the trie lookup block.
// Depends on nothing; imported by every module of the block but lct_fifo.
package lct_pkg;

	localparam int INDEX_W = 12;
	localparam int SKIP_W  = 5;
	localparam int CHILD_W = 12;
	localparam int LEN_W   = 6;
	localparam int PORT_W  = 8;
	localparam int ADDR_W  = 32;
	localparam int POS_W   = 7;
	// wide enough to compare any index against a table size up to 2**20
	localparam int RANGE_W = 21;

	typedef enum logic [1:0] {
		KIND_NODE_WR = 2'd0,
		KIND_LEAF_WR = 2'd1,
		KIND_LOOKUP  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		OP_NODE_WR = 2'd0,
		OP_LEAF_WR = 2'd1,
		OP_LOOKUP  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		STATUS_MATCH     = 2'd0,
		STATUS_DEFAULT   = 2'd1,
		STATUS_MALFORMED = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_NODE,
		BK_STEP,
		BK_LEAF,
		BK_EMIT
	} back_state_t;

	typedef struct packed {
		logic [SKIP_W-1:0]  skip;
		logic [SKIP_W-1:0]  branch;
		logic [CHILD_W-1:0] child;
		logic               valid;
	} node_entry_t;

	typedef struct packed {
		logic [ADDR_W-1:0] prefix;
		logic [LEN_W-1:0]  len;
		logic [PORT_W-1:0] port;
	} leaf_entry_t;

	typedef struct packed {
		op_t                op;
		logic [INDEX_W-1:0] index;
		node_entry_t        node;
		leaf_entry_t        leaf;
		logic [ADDR_W-1:0]  address;
	} cmd_t;

	typedef struct packed {
		logic [PORT_W-1:0] port;
		status_t           status;
	} result_t;

endpackage

// File: src/lct_fifo.sv
// Small first-in first-out queue built from flops.
// Depends on nothing; used for the command queue and the result queue.
module lct_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] dout
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

// File: src/lct_front.sv
// Front end: accepts input items, classifies them and queues commands.
// Depends on lct_pkg and lct_fifo.
module lct_front import lct_pkg::*; #(
	parameter int NODE_ENTRIES = 4096,
	parameter int LEAF_ENTRIES = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         kind,
	input  logic [INDEX_W-1:0] entry_index,
	input  logic [SKIP_W-1:0]  node_skip,
	input  logic [SKIP_W-1:0]  node_branch,
	input  logic [CHILD_W-1:0] node_child,
	input  logic               node_child_valid,
	input  logic [ADDR_W-1:0]  leaf_prefix,
	input  logic [LEN_W-1:0]   leaf_prefix_len,
	input  logic [PORT_W-1:0]  leaf_port,
	input  logic [ADDR_W-1:0]  address,
	input  logic               cmd_pop,
	output logic               cmd_empty,
	output cmd_t               cmd
);

	logic               accept;
	logic               keep;
	logic               node_in_range, leaf_in_range;
	logic [RANGE_W-1:0] index_ext;
	cmd_t               cmd_in;
	logic [$bits(cmd_t)-1:0] cmd_raw;

	assign accept    = push && !full;
	assign index_ext = RANGE_W'(entry_index);
	assign node_in_range = (index_ext < RANGE_W'(NODE_ENTRIES));
	assign leaf_in_range = (index_ext < RANGE_W'(LEAF_ENTRIES));

	// Drop unknown kinds and writes beyond the table; they leave no trace.
	always_comb begin
		cmd_in.index        = entry_index;
		cmd_in.node.skip    = node_skip;
		cmd_in.node.branch  = node_branch;
		cmd_in.node.child   = node_child;
		cmd_in.node.valid   = node_child_valid;
		cmd_in.leaf.prefix  = leaf_prefix;
		cmd_in.leaf.len     = leaf_prefix_len;
		cmd_in.leaf.port    = leaf_port;
		cmd_in.address      = address;
		cmd_in.op           = OP_LOOKUP;
		keep                = 1'b0;
		case (kind_t'(kind))
			KIND_NODE_WR: begin
				cmd_in.op = OP_NODE_WR;
				keep      = node_in_range;
			end
			KIND_LEAF_WR: begin
				cmd_in.op = OP_LEAF_WR;
				keep      = leaf_in_range;
			end
			KIND_LOOKUP: begin
				cmd_in.op = OP_LOOKUP;
				keep      = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	lct_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (2)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept && keep),
		.full   (full),
		.din    (cmd_in),
		.pop    (cmd_pop),
		.empty  (cmd_empty),
		.dout   (cmd_raw)
	);

	assign cmd = cmd_t'(cmd_raw);

endmodule

// File: src/lct_back.sv
// Back end: owns the node and leaf tables, applies writes and walks lookups.
// Depends on lct_pkg and the assertion macro header.
`include "lc_trie_longest_prefix_lookup_assert.svh"

module lct_back import lct_pkg::*; #(
	parameter int NODE_ENTRIES = 4096,
	parameter int LEAF_ENTRIES = 4096,
	parameter int ADDRESS_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [PORT_W-1:0] cfg_wr_data,
	input  logic              cmd_empty,
	input  cmd_t              cmd,
	output logic              cmd_pop,
	input  logic              res_full,
	output logic              res_push,
	output result_t           res
);

	localparam int NODE_AW = $clog2(NODE_ENTRIES);
	localparam int LEAF_AW = (LEAF_ENTRIES > 1) ? $clog2(LEAF_ENTRIES) : 1;
	localparam int AB      = ADDRESS_BITS;
	localparam int SUM_W   = ((AB > RANGE_W - 1) ? AB : RANGE_W - 1) + 1;
	localparam logic [POS_W-1:0] AB_POS = POS_W'(AB);

	node_entry_t node_mem [NODE_ENTRIES];
	leaf_entry_t leaf_mem [LEAF_ENTRIES];

	back_state_t state_q, state_nxt;
	node_entry_t node_rd_q;
	leaf_entry_t leaf_rd_q;
	logic [AB-1:0]      addr_q;
	logic [POS_W-1:0]   pos_q, end_q;
	logic [SKIP_W-1:0]  br_q;
	logic [CHILD_W-1:0] child_q;
	logic [PORT_W-1:0]  fallback_port_q;
	result_t            res_q;

	logic               node_we, node_re, leaf_we, leaf_re;
	logic [NODE_AW-1:0] node_waddr, node_raddr;
	logic [LEAF_AW-1:0] leaf_waddr, leaf_raddr;
	logic [POS_W-1:0]   eff_pos, walk_end, shift_amt;
	logic               walk_over, leaf_oob, next_oob, prefix_hit;
	logic [RANGE_W-1:0] child_ext, index_ext;
	logic [AB-1:0]      branch_mask, branch_bits, pmask;
	logic [SUM_W-1:0]   next_sum;
	logic [LEN_W-1:0]   len_sat;

	// Node datapath: position after this node's skip, and end of its branch bits.
	assign eff_pos   = pos_q + POS_W'(node_rd_q.skip);
	assign walk_end  = eff_pos + POS_W'(node_rd_q.branch);
	assign walk_over = (walk_end > AB_POS);
	assign child_ext = RANGE_W'(node_rd_q.child);
	assign leaf_oob  = (child_ext >= RANGE_W'(LEAF_ENTRIES));
	assign index_ext = RANGE_W'(cmd.index);

	// Step datapath: pick branch bits, add child base, check node range.
	assign shift_amt   = AB_POS - end_q;
	assign branch_mask = ~({AB{1'b1}} << br_q);
	assign branch_bits = (addr_q >> shift_amt) & branch_mask;
	assign next_sum    = SUM_W'(child_q) + SUM_W'(branch_bits);
	assign next_oob    = (next_sum >= SUM_W'(NODE_ENTRIES));

	// Leaf compare under a mask of the leading len_sat bits.
	assign len_sat = (leaf_rd_q.len > LEN_W'(AB)) ? LEN_W'(AB) : leaf_rd_q.len;
	always_comb begin
		for (int i = 0; i < AB; i++) begin
			pmask[i] = ((POS_W'(i) + POS_W'(len_sat)) >= AB_POS);
		end
	end
	assign prefix_hit = ((addr_q & pmask) == (leaf_rd_q.prefix[AB-1:0] & pmask));

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!cmd_empty && cmd.op == OP_LOOKUP) begin
					state_nxt = BK_NODE;
				end
			end
			BK_NODE: begin
				if (node_rd_q.branch == '0) begin
					state_nxt = (!node_rd_q.valid || leaf_oob) ? BK_EMIT : BK_LEAF;
				end else begin
					state_nxt = (walk_over || !node_rd_q.valid) ? BK_EMIT : BK_STEP;
				end
			end
			BK_STEP: state_nxt = next_oob ? BK_EMIT : BK_NODE;
			BK_LEAF: state_nxt = BK_EMIT;
			BK_EMIT: begin
				if (!res_full) begin
					state_nxt = BK_IDLE;
				end
			end
			default: state_nxt = BK_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd_pop    = 1'b0;
		node_we    = 1'b0;
		leaf_we    = 1'b0;
		node_re    = 1'b0;
		leaf_re    = 1'b0;
		res_push   = 1'b0;
		node_waddr = index_ext[NODE_AW-1:0];
		leaf_waddr = index_ext[LEAF_AW-1:0];
		node_raddr = '0;
		leaf_raddr = child_ext[LEAF_AW-1:0];
		case (state_q)
			BK_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					case (cmd.op)
						OP_NODE_WR: node_we = 1'b1;
						OP_LEAF_WR: leaf_we = 1'b1;
						OP_LOOKUP:  node_re = 1'b1;
						default:    cmd_pop = 1'b1;
					endcase
				end
			end
			BK_NODE: begin
				leaf_re = (node_rd_q.branch == '0) && node_rd_q.valid && !leaf_oob;
			end
			BK_STEP: begin
				node_re    = !next_oob;
				node_raddr = next_sum[NODE_AW-1:0];
			end
			BK_EMIT: res_push = !res_full;
			default: cmd_pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= BK_IDLE;
			fallback_port_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (cfg_wr_en) begin
				fallback_port_q <= cfg_wr_data;
			end
		end
	end

	// Walk registers and the pending result.
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				addr_q       <= cmd.address[AB-1:0];
				pos_q        <= '0;
				res_q.port   <= fallback_port_q;
				res_q.status <= STATUS_DEFAULT;
			end
			BK_NODE: begin
				end_q   <= walk_end;
				br_q    <= node_rd_q.branch;
				child_q <= node_rd_q.child;
				if (node_rd_q.branch == '0) begin
					if (node_rd_q.valid && leaf_oob) begin
						res_q.status <= STATUS_MALFORMED;
					end
				end else if (walk_over) begin
					res_q.status <= STATUS_MALFORMED;
				end
			end
			BK_STEP: begin
				pos_q <= end_q;
				if (next_oob) begin
					res_q.status <= STATUS_MALFORMED;
				end
			end
			BK_LEAF: begin
				if (prefix_hit) begin
					res_q.port   <= leaf_rd_q.port;
					res_q.status <= STATUS_MATCH;
				end
			end
			default: res_q <= res_q;
		endcase
	end

	// Tables: one write port and one registered read port each.
	always_ff @(posedge clk) begin
		if (node_we) begin
			node_mem[node_waddr] <= cmd.node;
		end
		if (node_re) begin
			node_rd_q <= node_mem[node_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (leaf_we) begin
			leaf_mem[leaf_waddr] <= cmd.leaf;
		end
		if (leaf_re) begin
			leaf_rd_q <= leaf_mem[leaf_raddr];
		end
	end

	assign res = res_q;

	`LCT_ASSERT_IMP(a_push_room, clk, arst_n, res_push, !res_full,
		"result pushed into a full queue")
	`LCT_ASSERT_IMP(a_pop_idle, clk, arst_n, cmd_pop, state_q == BK_IDLE && !cmd_empty,
		"command taken outside idle")
	`LCT_ASSERT_IMP(a_step_inside, clk, arst_n, state_q == BK_STEP, end_q <= AB_POS,
		"branch bits run past the address")
	`LCT_ASSERT_NXT(a_leaf_next, clk, arst_n, leaf_re, state_q == BK_LEAF,
		"leaf read not followed by leaf check")

endmodule

// File: src/lc_trie_longest_prefix_lookup.sv
// Top level of the level-compressed trie longest-prefix lookup block.
// Depends on lct_pkg, lct_front, lct_back and lct_fifo.
//
// Software loads the node table and the leaf table first, one entry per
// transfer (kind 0 node, kind 1 leaf); writes beyond a table and kind 3 are
// dropped and give no result. A lookup transfer (kind 2) gives exactly one
// result: the port of the leaf it reaches when the leaf prefix matches
// (status 0), otherwise the fallback port with status 1, or status 2 when the
// walk runs past the address or a child lies outside its table. There is no
// fallback to shorter prefixes. A front part takes transfers into a two-entry
// command queue, so input keeps flowing while the back part works; results
// wait in a two-entry result queue. The back part handles one command at a
// time; in a lookup each level waits on one registered read of the single
// read port of the node table. The tables are not cleared by reset; a lookup
// must only touch entries that were written. The fallback port resets to 0
// and is written through cfg_wr_en/cfg_wr_data; the user must write it only
// while the block is idle, the block itself does not enforce it.
module lc_trie_longest_prefix_lookup import lct_pkg::*; #(
	parameter int NODE_ENTRIES = 4096,
	parameter int LEAF_ENTRIES = 4096,
	parameter int ADDRESS_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	// input queue side
	input  logic               push,
	output logic               full,
	input  logic [1:0]         kind,
	input  logic [INDEX_W-1:0] entry_index,
	input  logic [SKIP_W-1:0]  node_skip,
	input  logic [SKIP_W-1:0]  node_branch,
	input  logic [CHILD_W-1:0] node_child,
	input  logic               node_child_valid,
	input  logic [ADDR_W-1:0]  leaf_prefix,
	input  logic [LEN_W-1:0]   leaf_prefix_len,
	input  logic [PORT_W-1:0]  leaf_port,
	input  logic [ADDR_W-1:0]  address,
	// result queue side
	output logic               empty,
	input  logic               pop,
	output logic [PORT_W-1:0]  egress_port,
	output logic [1:0]         status,
	// fallback port register
	input  logic               cfg_wr_en,
	input  logic [PORT_W-1:0]  cfg_wr_data
);

	cmd_t    cmd;
	logic    cmd_pop, cmd_empty;
	logic    res_push, res_full;
	result_t res_in, res_out;
	logic [$bits(result_t)-1:0] res_raw;

	// Classify and queue incoming transfers.
	lct_front #(
		.NODE_ENTRIES (NODE_ENTRIES),
		.LEAF_ENTRIES (LEAF_ENTRIES)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.kind             (kind),
		.entry_index      (entry_index),
		.node_skip        (node_skip),
		.node_branch      (node_branch),
		.node_child       (node_child),
		.node_child_valid (node_child_valid),
		.leaf_prefix      (leaf_prefix),
		.leaf_prefix_len  (leaf_prefix_len),
		.leaf_port        (leaf_port),
		.address          (address),
		.cmd_pop          (cmd_pop),
		.cmd_empty        (cmd_empty),
		.cmd              (cmd)
	);

	// Apply writes and walk the trie one level at a time.
	lct_back #(
		.NODE_ENTRIES (NODE_ENTRIES),
		.LEAF_ENTRIES (LEAF_ENTRIES),
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd_empty   (cmd_empty),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop),
		.res_full    (res_full),
		.res_push    (res_push),
		.res         (res_in)
	);

	// Hold finished results until the consumer takes them.
	lct_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (2)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.full   (res_full),
		.din    (res_in),
		.pop    (pop),
		.empty  (empty),
		.dout   (res_raw)
	);

	assign res_out     = result_t'(res_raw);
	assign egress_port = res_out.port;
	assign status      = res_out.status;

endmodule
